// File: hdl/labrgb_pkg.sv
`timescale 1ns / 1ps
package labrgb_pkg;

  localparam int FRAC_BITS_DEF        = 16;
  localparam int GAMMA_TABLE_BITS_DEF = 10;

  typedef logic signed [63:0] lut_s_t [256];
  typedef logic        [63:0] lut_u_t [256];

  // L* = floor(raw * 100 / 255)
  function automatic longint lum_of(input int x);
    return (longint'(x) * 100) / 255;
  endfunction

  function automatic lut_s_t fy_tab(input int n);
    lut_s_t t;
    longint l;
    for (int x = 0; x < 256; x++) begin
      l    = lum_of(x);
      t[x] = ((l + 16) <<< n) / 116;
    end
    return t;
  endfunction

  // Y depends on L only: cube of fy above L*=8, linear segment at or below
  function automatic lut_s_t vy_tab(input int n);
    lut_s_t t;
    longint l;
    longint f;
    longint s;
    for (int x = 0; x < 256; x++) begin
      l = lum_of(x);
      if (l > 8) begin
        f    = ((l + 16) <<< n) / 116;
        s    = (f * f) >>> n;
        t[x] = (s * f) >>> n;
      end else begin
        t[x] = ((l * 27) <<< n) / 24389;
      end
    end
    return t;
  endfunction

  function automatic lut_s_t ga_tab(input int n);
    lut_s_t t;
    for (int x = 0; x < 256; x++) begin
      t[x] = ((longint'(x) - 128) <<< n) / 500;
    end
    return t;
  endfunction

  function automatic lut_s_t by_tab(input int n);
    lut_s_t t;
    for (int x = 0; x < 256; x++) begin
      t[x] = ((longint'(x) - 128) <<< n) / 200;
    end
    return t;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned x0);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = x0;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // (y/255)^(563/256) in Q30
  function automatic longint unsigned threshold(input int y);
    longint unsigned w;
    longint unsigned res;
    int unsigned     e;
    w   = (longint'(y) << 30) / 255;
    res = 64'd1 << 30;
    e   = 563;
    for (int i = 0; i < 8; i++) begin
      w = isqrt64(w << 30);
    end
    while (e != 0) begin
      if (e[0]) res = (res * w) >> 30;
      w = (w * w) >> 30;
      e = e >> 1;
    end
    return res;
  endfunction

  // Lowest gamma address at which output code y is reached; nondecreasing in y.
  function automatic lut_u_t gamma_addr_tab(input int g);
    lut_u_t          t;
    longint unsigned m;
    m    = (64'd1 << g) - 1;
    t[0] = '0;
    for (int y = 1; y < 256; y++) begin
      t[y] = (threshold(y) * m + (64'd1 << 30) - 1) >> 30;
    end
    return t;
  endfunction

endpackage

// File: hdl/lab_to_rgb_pixel_converter.sv
`timescale 1ns / 1ps
// Lab to RGB pixel converter.
// Input channel: in_valid_i / in_stall_o with lightness, a, b and alpha bytes.
// Output channel: out_valid_o / out_stall_i with red, green, blue and the
// inverted alpha. A beat moves when valid is high and stall is low.
// Every pixel is independent and walks an 18-stage pipeline: lookup of the
// L, a, b terms, the inverse companding (cube and the linear segment, whose
// divide by 24389 is a reciprocal multiply with one correction step), the
// white scaling, the 3x3 matrix, the gamma address and an 8-step binary
// search over the gamma code boundaries, one step per stage.
// Throughput is one pixel per clock while the receiver does not stall.
// Each stage holds its beat only when the stage after it is blocked, so
// bubbles close up and new input is taken while a finished pixel waits.
// in_stall_o rises only when every stage is full and the receiver stalls.
// Reset clears all stage valid bits; no pixel is in flight afterwards.
// The gamma tables are constants built at elaboration, no fill time.
module lab_to_rgb_pixel_converter #(
  parameter int FRAC_BITS        = labrgb_pkg::FRAC_BITS_DEF,
  parameter int GAMMA_TABLE_BITS = labrgb_pkg::GAMMA_TABLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] lightness_i,
  input  logic [7:0] green_red_axis_i,
  input  logic [7:0] blue_yellow_axis_i,
  input  logic [7:0] alpha_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_out_o
);

  localparam int N    = FRAC_BITS;
  localparam int G    = GAMMA_TABLE_BITS;
  localparam int NST  = 18;
  localparam int SRCH = 10;            // first search stage
  localparam int FW   = N + 3;         // f values
  localparam int UW   = N + 9;         // 116*f - 16
  localparam int MW   = N + 13;        // |27*u|
  localparam int TW   = MW + 1;
  localparam int QW   = MW - 14;       // quotient by 24389
  localparam int VW   = N + 5;         // XYZ values
  localparam int KW   = N + 3;         // constants
  localparam int PW   = KW + VW;       // constant products
  localparam int SQW  = 2 * FW;
  localparam int CBW  = 2 * N + 6;
  localparam int CW   = N + 7;         // RGB sums
  localparam int AMW  = N + G;

  localparam longint ONE   = longint'(1) <<< N;
  localparam longint RECIP = (longint'(1) <<< MW) / 24389;
  localparam longint EQ    = (216 * ONE) / 24389;
  localparam longint GMAX  = (longint'(1) <<< G) - 1;
  localparam longint DEN   = 10000000;

  localparam logic [QW-1:0]        RECIP_V = QW'(RECIP);
  localparam logic [MW-1:0]        DIV_D   = MW'(24389);
  localparam logic signed [VW-1:0] EQ_V    = VW'(EQ);
  localparam logic signed [KW-1:0] KX      = KW'((9605 * ONE + 5000) / 10000);
  localparam logic signed [KW-1:0] KZ      = KW'((10891 * ONE + 5000) / 10000);
  localparam logic signed [KW-1:0] KM [9] = '{
    KW'((20413690 * ONE + DEN / 2) / DEN),  -KW'((5649464 * ONE + DEN / 2) / DEN),
    -KW'((3446944 * ONE + DEN / 2) / DEN), -KW'((9692660 * ONE + DEN / 2) / DEN),
    KW'((18760108 * ONE + DEN / 2) / DEN),  KW'((415560 * ONE + DEN / 2) / DEN),
    KW'((134474 * ONE + DEN / 2) / DEN),   -KW'((1183897 * ONE + DEN / 2) / DEN),
    KW'((10154096 * ONE + DEN / 2) / DEN)
  };

  localparam labrgb_pkg::lut_s_t FY_TAB = labrgb_pkg::fy_tab(N);
  localparam labrgb_pkg::lut_s_t VY_TAB = labrgb_pkg::vy_tab(N);
  localparam labrgb_pkg::lut_s_t GA_TAB = labrgb_pkg::ga_tab(N);
  localparam labrgb_pkg::lut_s_t BY_TAB = labrgb_pkg::by_tab(N);
  localparam labrgb_pkg::lut_u_t AY_TAB = labrgb_pkg::gamma_addr_tab(G);

  function automatic logic signed [VW-1:0] tz_shift(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] a;
    a = p + (p[PW-1] ? PW'(ONE - 1) : PW'(0));
    return VW'(a >>> N);
  endfunction

  // ---- stage control ----
  logic [NST-1:0] v_q;
  logic [NST:0]   en;
  logic [NST-1:0] v_src;

  always_comb begin
    en[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_src      = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_src[k];
      end
    end
  end

  // alpha and Y ride along
  logic [7:0]          al_q [NST];
  logic signed [VW-1:0] vy_q [6];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      al_q[0] <= ~alpha_in_i;
      vy_q[0] <= VW'(VY_TAB[lightness_i]);
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) al_q[k] <= al_q[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k]) vy_q[k] <= vy_q[k-1];
    end
  end

  // ---- stage 0: table lookups ----
  logic signed [FW-1:0] fy0_q;
  logic signed [FW-1:0] d0_q [2];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fy0_q   <= FW'(FY_TAB[lightness_i]);
      d0_q[0] <= FW'(GA_TAB[green_red_axis_i]);
      d0_q[1] <= -FW'(BY_TAB[blue_yellow_axis_i]);
    end
  end

  // ---- stage 1: f and linear segment numerator ----
  logic signed [FW-1:0] f1_d [2];
  logic [MW-1:0]        m1_d [2];
  logic                 s1_d [2];
  logic signed [FW-1:0] f1_q [2];
  logic [MW-1:0]        m1_q [2];
  logic                 s1_q [2];

  always_comb begin
    logic signed [UW-1:0] u;
    logic signed [TW-1:0] t;
    for (int i = 0; i < 2; i++) begin
      f1_d[i] = fy0_q + d0_q[i];
      u       = UW'(f1_d[i]) * UW'(116) - UW'(16 * ONE);
      t       = TW'(u) * TW'(27);
      s1_d[i] = t[TW-1];
      m1_d[i] = t[TW-1] ? MW'(-t) : MW'(t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      f1_q <= f1_d;
      m1_q <= m1_d;
      s1_q <= s1_d;
    end
  end

  // ---- stage 2: square and reciprocal estimate ----
  logic signed [SQW-1:0] sq2_q [2];
  logic [QW-1:0]         q2_q  [2];
  logic [MW-1:0]         m2_q  [2];
  logic                  s2_q  [2];
  logic signed [FW-1:0]  f2_q  [2];

  always_ff @(posedge clk_i) begin
    logic [MW+QW-1:0] pq;
    if (en[2]) begin
      for (int i = 0; i < 2; i++) begin
        pq       = (MW+QW)'(m1_q[i]) * (MW+QW)'(RECIP_V);
        q2_q[i]  <= pq[MW+QW-1:MW];
        sq2_q[i] <= SQW'(f1_q[i]) * SQW'(f1_q[i]);
        m2_q[i]  <= m1_q[i];
        s2_q[i]  <= s1_q[i];
        f2_q[i]  <= f1_q[i];
      end
    end
  end

  // ---- stage 3: cube and remainder ----
  logic signed [CBW-1:0] cb3_q [2];
  logic [MW-1:0]         r3_q  [2];
  logic [QW-1:0]         q3_q  [2];
  logic                  s3_q  [2];

  always_ff @(posedge clk_i) begin
    logic [N+2:0] sqs;
    if (en[3]) begin
      for (int i = 0; i < 2; i++) begin
        sqs      = sq2_q[i][2*N+2:N];
        cb3_q[i] <= CBW'($signed({1'b0, sqs})) * CBW'(f2_q[i]);
        r3_q[i]  <= m2_q[i] - MW'(q2_q[i]) * DIV_D;
        q3_q[i]  <= q2_q[i];
        s3_q[i]  <= s2_q[i];
      end
    end
  end

  // ---- stage 4: branch select ----
  logic signed [VW-1:0] v4_q [2];

  always_ff @(posedge clk_i) begin
    logic signed [CBW-1:0] ca;
    logic signed [VW-1:0]  c;
    logic signed [VW-1:0]  q;
    if (en[4]) begin
      for (int i = 0; i < 2; i++) begin
        ca      = cb3_q[i] + (cb3_q[i][CBW-1] ? CBW'(ONE - 1) : CBW'(0));
        c       = VW'(ca >>> N);
        q       = VW'(q3_q[i]) + VW'(r3_q[i] >= DIV_D);
        v4_q[i] <= (c > EQ_V) ? c : (s3_q[i] ? -q : q);
      end
    end
  end

  // ---- stage 5: white point scaling ----
  logic signed [PW-1:0] p5_q [2];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      p5_q[0] <= PW'(KX) * PW'(v4_q[0]);
      p5_q[1] <= PW'(KZ) * PW'(v4_q[1]);
    end
  end

  // ---- stage 6: matrix products ----
  logic signed [PW-1:0] p6_q [9];

  always_ff @(posedge clk_i) begin
    logic signed [VW-1:0] opnd [3];
    if (en[6]) begin
      opnd[0] = tz_shift(p5_q[0]);
      opnd[1] = vy_q[5];
      opnd[2] = tz_shift(p5_q[1]);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p6_q[3*r+c] <= PW'(KM[3*r+c]) * PW'(opnd[c]);
        end
      end
    end
  end

  // ---- stage 7: row sums ----
  logic signed [CW-1:0] ch7_q [3];

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int r = 0; r < 3; r++) begin
        ch7_q[r] <= CW'(tz_shift(p6_q[3*r])) + CW'(tz_shift(p6_q[3*r+1]))
                  + CW'(tz_shift(p6_q[3*r+2]));
      end
    end
  end

  // ---- stage 8: gamma address product ----
  logic [AMW-1:0] pa8_q [3];
  logic           ng8_q [3];
  logic           ov8_q [3];

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int r = 0; r < 3; r++) begin
        pa8_q[r] <= AMW'(ch7_q[r][N-1:0]) * AMW'(GMAX);
        ng8_q[r] <= (ch7_q[r] <= CW'(0));
        ov8_q[r] <= (ch7_q[r] >= CW'(ONE));
      end
    end
  end

  // ---- stage 9: round and cap address ----
  logic [G-1:0] a9_q [3];

  always_ff @(posedge clk_i) begin
    logic [AMW:0] sum;
    logic [G:0]   sh;
    if (en[9]) begin
      for (int r = 0; r < 3; r++) begin
        sum = (AMW+1)'(pa8_q[r]) + (AMW+1)'(ONE >>> 1);
        sh  = sum[AMW:N];
        if (ng8_q[r]) begin
          a9_q[r] <= '0;
        end else if (ov8_q[r] || sh > (G+1)'(GMAX)) begin
          a9_q[r] <= G'(GMAX);
        end else begin
          a9_q[r] <= sh[G-1:0];
        end
      end
    end
  end

  // ---- stages 10..17: binary search for the output code ----
  logic [G-1:0] sa_q [8][3];
  logic [7:0]   sy_q [8][3];

  for (genvar j = 0; j < 8; j++) begin : g_search
    always_ff @(posedge clk_i) begin
      logic [G-1:0] a_in;
      logic [7:0]   y_in;
      logic [7:0]   cand;
      if (en[SRCH+j]) begin
        for (int r = 0; r < 3; r++) begin
          a_in = (j == 0) ? a9_q[r] : sa_q[(j == 0) ? 0 : j-1][r];
          y_in = (j == 0) ? 8'd0 : sy_q[(j == 0) ? 0 : j-1][r];
          cand = y_in | (8'd1 << (7 - j));
          sa_q[j][r] <= a_in;
          sy_q[j][r] <= (AY_TAB[cand] <= 64'(a_in)) ? cand : y_in;
        end
      end
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign red_o       = sy_q[7][0];
  assign green_o     = sy_q[7][1];
  assign blue_o      = sy_q[7][2];
  assign alpha_out_o = al_q[NST-1];

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&v_q)))
    else $error("input stalled while pipeline has room");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat missing from first stage");

  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !en[5]) |=> (v_q[4] && $stable(v4_q[0]) && $stable(v4_q[1])))
    else $error("blocked stage lost or changed its beat");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int  FRAC = 16;
  localparam int  GBITS = 10;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint unsigned GMAX = (64'd1 << GBITS) - 1;
  localparam longint unsigned G_ONE = 64'd1 << 30;
  localparam int  LIMIT = 400000;

  typedef struct packed {
    logic [7:0] l;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] alpha;
  } lab_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] alpha;
  } rgb_pix_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] lightness_i = '0;
  logic [7:0] green_red_axis_i = '0;
  logic [7:0] blue_yellow_axis_i = '0;
  logic [7:0] alpha_in_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] red_o, green_o, blue_o, alpha_out_o;

  lab_to_rgb_pixel_converter dut (.*);

  always #5 clk_i = ~clk_i;

  lab_pix_t pending_pix[$];
  rgb_pix_t expected_rgb[$];
  byte unsigned gamma_lut[1 << GBITS];
  int  beats_in = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // (y/255)^(563/256) in Q30: 256th root by eight square roots, then power 563
  function automatic longint unsigned code_edge(input int y);
    longint unsigned w, acc;
    int unsigned     e;
    w = (longint'(y) << 30) / 255;
    acc = G_ONE;
    e = 563;
    for (int i = 0; i < 8; i++) w = int_sqrt(w << 30);
    while (e != 0) begin
      if (e[0]) acc = (acc * w) >> 30;
      w = (w * w) >> 30;
      e = e >> 1;
    end
    return acc;
  endfunction

  task automatic fill_gamma_lut();
    longint unsigned edges[256];
    longint unsigned u;
    int y;
    edges[0] = 0;
    for (int k = 1; k < 256; k++) edges[k] = code_edge(k);
    y = 1;
    for (longint unsigned ad = 0; ad <= GMAX; ad++) begin
      u = (ad << 30) / GMAX;
      while (y <= 255 && edges[y] <= u) y++;
      gamma_lut[ad] = byte'(y - 1);
    end
  endtask

  function automatic longint qmul(input longint x, input longint y);
    return (x * y) / ONE;
  endfunction

  function automatic longint qconst(input longint n, input longint d);
    return (n * ONE + d / 2) / d;
  endfunction

  function automatic longint lab_f_inv(input longint f);
    longint c;
    c = qmul(qmul(f, f), f);
    if (c > (216 * ONE) / 24389) return c;
    return ((116 * f - 16 * ONE) * 27) / 24389;
  endfunction

  function automatic logic [7:0] gamma_code(input longint v);
    longint unsigned ad;
    if (v <= 0) return 8'd0;
    if (v >= ONE) return 8'd255;
    ad = (longint'(v) * GMAX + (ONE >> 1)) >> FRAC;
    if (ad > GMAX) ad = GMAX;
    return gamma_lut[ad];
  endfunction

  function automatic rgb_pix_t lab_to_rgb(input lab_pix_t p);
    longint lum, ga, by, fy, fx, fz, vx, vy, vz, xs, zs, r, g, b;
    rgb_pix_t o;
    lum = (longint'(p.l) * 100) / 255;
    ga = longint'(p.a) - 128;
    by = longint'(p.b) - 128;
    fy = ((lum + 16) * ONE) / 116;
    fx = fy + (ga * ONE) / 500;
    fz = fy - (by * ONE) / 200;
    vy = (lum > 8) ? qmul(qmul(fy, fy), fy) : (lum * 27 * ONE) / 24389;
    vx = lab_f_inv(fx);
    vz = lab_f_inv(fz);
    xs = qmul(qconst(9605, 10000), vx);
    zs = qmul(qconst(10891, 10000), vz);
    r = qmul(qconst(20413690, 10000000), xs) - qmul(qconst(5649464, 10000000), vy)
        - qmul(qconst(3446944, 10000000), zs);
    g = -qmul(qconst(9692660, 10000000), xs) + qmul(qconst(18760108, 10000000), vy)
        + qmul(qconst(415560, 10000000), zs);
    b = qmul(qconst(134474, 10000000), xs) - qmul(qconst(1183897, 10000000), vy)
        + qmul(qconst(10154096, 10000000), zs);
    o.r = gamma_code(r);
    o.g = gamma_code(g);
    o.b = gamma_code(b);
    o.alpha = 8'd255 - p.alpha;
    return o;
  endfunction

  // sender
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    lab_pix_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        p = '{lightness_i, green_red_axis_i, blue_yellow_axis_i, alpha_in_i};
        expected_rgb.push_back(lab_to_rgb(p));
        beats_in++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pix.size() > 0) begin
          p = pending_pix.pop_front();
          lightness_i <= p.l;
          green_red_axis_i <= p.a;
          blue_yellow_axis_i <= p.b;
          alpha_in_i <= p.alpha;
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the pipeline backs up
  int  sink_hold = 0;
  bit  long_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!long_done && beats_in >= 400) begin
        long_done = 1'b1;
        sink_hold = 90;
      end else if (sink_hold == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        sink_hold = $urandom_range(1, 9);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rgb_pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h %h %h %h",
                                       red_o, green_o, blue_o, alpha_out_o);
      end else begin
        want = expected_rgb.pop_front();
        if (want !== {red_o, green_o, blue_o, alpha_out_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                     want.r, want.g, want.b, want.alpha,
                     red_o, green_o, blue_o, alpha_out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    lab_pix_t p;
    byte unsigned edge_vals[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    fill_gamma_lut();
    // L* near the cube / linear split: raw 20 -> 7, 22 -> 8, 23 -> 9
    pending_pix.push_back('{8'd20, 8'd128, 8'd128, 8'd255});
    pending_pix.push_back('{8'd22, 8'd128, 8'd128, 8'd0});
    pending_pix.push_back('{8'd23, 8'd128, 8'd128, 8'd170});
    for (int i = 0; i < 6; i++) begin
      pending_pix.push_back('{edge_vals[i], edge_vals[5 - i], edge_vals[i], edge_vals[i]});
      pending_pix.push_back('{edge_vals[5 - i], edge_vals[i], edge_vals[(i + 2) % 6], 8'h55});
    end
    // saturating and negative channels
    pending_pix.push_back('{8'd255, 8'd255, 8'd0, 8'd1});
    pending_pix.push_back('{8'd255, 8'd0, 8'd255, 8'd254});
    pending_pix.push_back('{8'd0, 8'd0, 8'd0, 8'd128});
    pending_pix.push_back('{8'd0, 8'd255, 8'd255, 8'd127});
    pending_pix.push_back('{8'd128, 8'd128, 8'd128, 8'h0f});
    for (int i = 0; i < 1900; i++) begin
      p = $urandom;
      if ($urandom_range(0, 3) == 0) p.l = 8'($urandom_range(0, 30));
      pending_pix.push_back(p);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pix.size() < 200);
    quiet = 1'b1;
    wait (pending_pix.size() == 0 && !in_valid_i && expected_rgb.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
